/* rtl/md5_pkg.sv */
`default_nettype none
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    localparam logic [31:0] ROUND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMOUNT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word index for a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] i4;
        begin
            i4 = rnd[3:0];
            case (rnd[5:4])
                2'd0: msg_index = i4;
                2'd1: msg_index = 4'((i4 << 2) + i4 + 4'd1);
                2'd2: msg_index = 4'((i4 << 1) + i4 + 4'd5);
                default: msg_index = 4'((i4 << 3) - i4);
            endcase
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/md5_message_digest_core.sv */
// md5 message digest core
// input channel: data_byte / carries_byte / end_of_message with valid and
// stall; a request may carry a byte, an end-of-message mark, both or neither.
// output channel: four digest words (word_number 0..3, last_word on word 3)
// with valid and stall; bits 7:0 of word 0 are the first digest byte.
// a byte request is written into the 64-byte block buffer.
// when the 64th byte of a block arrives the shared round unit runs one
// md5 round per cycle: message words are first read from the buffer (one
// buffer read per cycle), then come 64 rounds, then a fold into the
// chain words; input stall is high throughout.
// at end of message the padding sequencer writes 0x80, zeros and the
// 8 length bytes one per cycle (one or two blocks), then
// the four digest words are presented one after another.
// the round unit sets the sustained byte rate: no byte is taken while a block runs.
// if the receiver stalls, the current digest word holds and the core
// waits; a new message is accepted only after word 3 has been taken.
// reset (rst_n low, asynchronous) loads the md5 initial chain values,
// clears the bit count and returns the sequencer to idle.
`default_nettype none
module md5_message_digest_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        carries_byte,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [1:0]       word_number,
    output logic             last_word
);
    import md5_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;  // read message words from buffer
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] msg_reg [16];
    logic [63:0] bit_count_reg;
    logic [63:0] len_reg;            // latched message length for padding
    logic [5:0]  round_reg;
    logic [3:0]  load_reg;
    logic        pad_mode_reg;       // block run belongs to padding
    logic        pad_done_reg;       // length bytes written, emit after fold
    logic [5:0]  pad_fill_reg;       // fill level during padding
    logic        pad_first_reg;      // next pad byte is 0x80
    logic        pad_len_ok_reg;     // this pad block carries the length
    logic [1:0]  out_cnt_reg;

    // block buffer as four byte lanes, one word per entry
    logic [7:0]  buf_mem [4][16];
    logic [31:0] buf_rd_reg;

    logic [5:0]  fill;
    logic [5:0]  pad_start;
    logic        accept;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_byte;
    logic [7:0]  pad_byte;
    logic [2:0]  len_sel;

    assign fill      = bit_count_reg[8:3];
    assign pad_start = carries_byte ? 6'(fill + 6'd1) : fill;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;

    // padding byte for the current fill level
    assign len_sel = pad_fill_reg[2:0];
    always_comb
    begin
        if (pad_first_reg)
            pad_byte = PAD_BYTE;
        else if (pad_fill_reg >= LEN_POS && pad_len_ok_reg)
            pad_byte = len_reg[{len_sel, 3'b000} +: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill;
        wr_byte = data_byte;
        if (accept && carries_byte)
            wr_en = 1'b1;
        else if (state_reg == ST_PAD)
        begin
            wr_en   = 1'b1;
            wr_addr = pad_fill_reg;
            wr_byte = pad_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_addr[1:0]][wr_addr[5:2]] <= wr_byte;
        buf_rd_reg <= {buf_mem[3][load_reg], buf_mem[2][load_reg],
                       buf_mem[1][load_reg], buf_mem[0][load_reg]};
    end

    // round unit
    logic [31:0] f_val, sum_val, rot_val;
    logic [4:0]  rot_amt;
    always_comb
    begin
        case (round_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum_val = a_reg + f_val + ROUND_ADD[round_reg] + msg_reg[msg_index(round_reg)];
        rot_amt = ROT_AMOUNT[{round_reg[5:4], round_reg[1:0]}];
        rot_val = (sum_val << rot_amt) | (sum_val >> (6'd32 - {1'b0, rot_amt}));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (carries_byte && fill == 6'd63)
                        state_next = ST_LOAD;
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            ST_LOAD:
                if (load_reg == 4'd15)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (round_reg == 6'd63)
                    state_next = ST_FOLD;
            ST_FOLD:
                if (pad_done_reg)
                    state_next = ST_OUT;
                else if (pad_mode_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            ST_PAD:
                if (pad_fill_reg == 6'd63)
                    state_next = ST_LOAD;
            ST_OUT:
                if (!out_stall && out_cnt_reg == 2'd3)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chain_reg[0]   <= INIT_A;
            chain_reg[1]   <= INIT_B;
            chain_reg[2]   <= INIT_C;
            chain_reg[3]   <= INIT_D;
            bit_count_reg  <= '0;
            round_reg      <= '0;
            load_reg       <= '0;
            pad_mode_reg   <= 1'b0;
            pad_done_reg   <= 1'b0;
            pad_first_reg  <= 1'b0;
            pad_len_ok_reg <= 1'b0;
            pad_fill_reg   <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        if (carries_byte)
                            bit_count_reg <= bit_count_reg + 64'd8;
                        if (end_of_message)
                        begin
                            pad_mode_reg   <= 1'b1;
                            pad_first_reg  <= 1'b1;
                            pad_fill_reg   <= pad_start;
                            // 0x80 past byte 55 pushes the length to a second block
                            pad_len_ok_reg <= (pad_start < LEN_POS);
                        end
                    end
                ST_LOAD:
                    load_reg <= load_reg + 4'd1;
                ST_ROUND:
                    round_reg <= round_reg + 6'd1;
                ST_FOLD:
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    if (pad_done_reg)
                        out_cnt_reg <= '0;
                    if (pad_mode_reg && !pad_done_reg)
                        pad_len_ok_reg <= 1'b1;
                end
                ST_PAD:
                begin
                    pad_first_reg <= 1'b0;
                    pad_fill_reg  <= pad_fill_reg + 6'd1;
                    if (pad_fill_reg == 6'd63 && pad_len_ok_reg)
                        pad_done_reg <= 1'b1;
                end
                ST_OUT:
                    if (!out_stall)
                    begin
                        out_cnt_reg <= out_cnt_reg + 2'd1;
                        if (out_cnt_reg == 2'd3)
                        begin
                            chain_reg[0]  <= INIT_A;
                            chain_reg[1]  <= INIT_B;
                            chain_reg[2]  <= INIT_C;
                            chain_reg[3]  <= INIT_D;
                            bit_count_reg <= '0;
                            pad_mode_reg  <= 1'b0;
                            pad_done_reg  <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && end_of_message)
            len_reg <= carries_byte ? bit_count_reg + 64'd8 : bit_count_reg;
        if (state_reg == ST_LOAD)
        begin
            // buffer read is registered: store previous word
            if (load_reg != 4'd0)
                msg_reg[load_reg - 4'd1] <= buf_rd_reg;
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        if (state_reg == ST_ROUND)
        begin
            if (round_reg == 6'd0)
                msg_reg[15] <= buf_rd_reg;
            a_reg <= d_reg;
            b_reg <= b_reg + rot_val;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = chain_reg[out_cnt_reg];
    assign word_number = out_cnt_reg;
    assign last_word   = (out_cnt_reg == 2'd3);

endmodule
`default_nettype wire
